FILE: rtl/cevq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cevq_pkg
// Shared widths, operation codes, register indexes and the status record of
// the coalescing event queue.
// ----------------------------------------------------------------------------
package cevq_pkg;

    localparam int SRC_W   = 8;
    localparam int OP_W    = 2;
    localparam int CAP_W   = 5;
    localparam int FILL_W  = 5;
    localparam int TOTAL_W = 32;
    localparam int CFG_W   = 8;

    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_PAYLOAD_WIDTH = 64;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    localparam logic CFG_CAPACITY      = 1'b0;
    localparam logic CFG_SYSTEM_SOURCE = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic               ok;
        logic [FILL_W-1:0]  fill_level;
        logic               is_full;
        logic               is_empty;
        logic [TOTAL_W-1:0] coalesced_total;
    } status_t;

endpackage

FILE: rtl/cevq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cevq_store
// Entry memory of the queue: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module cevq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 72,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/cevq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cevq_ctrl
// Sequencer of the queue: scans the entry memory for a matching source,
// reads the head, closes gaps one entry at a time, appends, clears, and
// keeps the fill and coalesce counters.
// ----------------------------------------------------------------------------
module cevq_ctrl #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PAYLOAD_WIDTH = 64,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int EW = cevq_pkg::SRC_W + PAYLOAD_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cevq_pkg::OP_W-1:0]    in_op,
    input  logic [cevq_pkg::SRC_W-1:0]   in_source,
    input  logic [PAYLOAD_WIDTH-1:0]     in_payload,
    input  logic [cevq_pkg::CAP_W-1:0]   capacity,
    input  logic [cevq_pkg::SRC_W-1:0]   system_source,
    input  logic                         res_free,
    output logic                         res_done,
    output logic [cevq_pkg::SRC_W-1:0]   res_source,
    output logic [PAYLOAD_WIDTH-1:0]     res_payload,
    output cevq_pkg::status_t            res_status,
    output logic                         mem_wr_en,
    output logic [AW-1:0]                mem_wr_addr,
    output logic [EW-1:0]                mem_wr_data,
    output logic                         mem_rd_en,
    output logic [AW-1:0]                mem_rd_addr,
    input  logic [EW-1:0]                mem_rd_data
);

    import cevq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = 4;

    localparam logic [SW-1:0] ST_IDLE     = 4'd0;
    localparam logic [SW-1:0] ST_SCAN_RD  = 4'd1;
    localparam logic [SW-1:0] ST_SCAN_CMP = 4'd2;
    localparam logic [SW-1:0] ST_SHIFT_RD = 4'd3;
    localparam logic [SW-1:0] ST_SHIFT_WR = 4'd4;
    localparam logic [SW-1:0] ST_APPEND   = 4'd5;
    localparam logic [SW-1:0] ST_HEAD_RD  = 4'd6;
    localparam logic [SW-1:0] ST_HEAD_CAP = 4'd7;
    localparam logic [SW-1:0] ST_FINISH   = 4'd8;

    logic [SW-1:0]            state_reg,  state_next;
    logic [OP_W-1:0]          op_reg,     op_next;
    logic [SRC_W-1:0]         src_reg,    src_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg,    pay_next;
    logic [CW-1:0]            count_reg,  count_next;
    logic [CW-1:0]            idx_reg,    idx_next;
    logic [TOTAL_W-1:0]       total_reg,  total_next;
    logic                     ok_reg,     ok_next;
    logic [SRC_W-1:0]         osrc_reg,   osrc_next;
    logic [PAYLOAD_WIDTH-1:0] opay_reg,   opay_next;

    logic [CW-1:0] eff_cap;
    logic [CW-1:0] idx_inc;
    logic          hit;

    // The configured capacity saturates at the memory depth.
    always_comb
    begin
        if (int'(capacity) > QUEUE_DEPTH)
        begin
            eff_cap = CW'(QUEUE_DEPTH);
        end
        else
        begin
            eff_cap = CW'(capacity);
        end
    end

    assign idx_inc = idx_reg + 1'b1;
    assign hit     = (mem_rd_data[EW-1 -: SRC_W] == src_reg);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        src_next    = src_reg;
        pay_next    = pay_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        ok_next     = ok_reg;
        osrc_next   = osrc_reg;
        opay_next   = opay_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg[AW-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg[AW-1:0];
        res_done    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_op;
                    src_next  = in_source;
                    pay_next  = in_payload;
                    ok_next   = 1'b0;
                    osrc_next = '0;
                    opay_next = '0;
                    idx_next  = '0;
                    case (in_op)
                        OP_PUSH:
                        begin
                            if (in_source != system_source && count_reg != '0)
                            begin
                                state_next = ST_SCAN_RD;
                            end
                            else
                            begin
                                state_next = ST_APPEND;
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_HEAD_RD;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                            total_next = '0;
                            ok_next    = 1'b1;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (hit)
                begin
                    if (total_reg != '1)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    idx_next = idx_inc;
                    if (idx_inc == count_reg)
                    begin
                        state_next = ST_APPEND;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_inc[AW-1:0];
                    state_next  = ST_SHIFT_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (op_reg == OP_PUSH)
                    begin
                        state_next = ST_APPEND;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SHIFT_WR:
            begin
                mem_wr_en  = 1'b1;
                idx_next   = idx_inc;
                state_next = ST_SHIFT_RD;
            end
            ST_APPEND:
            begin
                if (count_reg < eff_cap)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = count_reg[AW-1:0];
                    mem_wr_data = {src_reg, pay_reg};
                    count_next  = count_reg + 1'b1;
                    ok_next     = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_HEAD_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_HEAD_CAP;
            end
            ST_HEAD_CAP:
            begin
                osrc_next = mem_rd_data[EW-1 -: SRC_W];
                opay_next = mem_rd_data[PAYLOAD_WIDTH-1:0];
                ok_next   = 1'b1;
                if (op_reg == OP_POP)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                res_done = res_free;
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
            op_reg    <= OP_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        pay_reg  <= pay_next;
        ok_reg   <= ok_next;
        osrc_reg <= osrc_next;
        opay_reg <= opay_next;
    end

    assign in_ready                   = (state_reg == ST_IDLE);
    assign res_source                 = osrc_reg;
    assign res_payload                = opay_reg;
    assign res_status.ok              = ok_reg;
    assign res_status.fill_level      = FILL_W'(count_reg);
    assign res_status.is_full         = (count_reg >= eff_cap);
    assign res_status.is_empty        = (count_reg == '0);
    assign res_status.coalesced_total = total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds the queue depth");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op == OP_CLEAR) |=>
            (count_reg == '0 && total_reg == '0))
        else $error("clear did not empty the queue and counter");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && in_op == OP_CLEAR) |=>
            (total_reg >= $past(total_reg)))
        else $error("coalesce counter fell without a clear");

    a_done_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        res_done |=> (state_reg == ST_IDLE && count_reg == $past(count_reg)))
        else $error("result handed off but sequencer did not return to idle");

endmodule

FILE: rtl/coalescing_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_event_queue
// Bounded ordered event queue in which a new event from a source other than
// the system source drops that source's oldest queued event and is appended.
// ----------------------------------------------------------------------------
// One item is worked at a time; s_tready is high only while the sequencer is
// idle, and a finished result waits in the output register while the next
// item is taken. A push from a source other than the system source scans the
// held entries from the head up to the first match, then closes the gap by
// moving each later entry one place toward the head, and appends; a pop reads
// the head and removes it the same way; a peek reads the head; a clear or a
// read of the empty queue goes straight to the result. A result that finds
// the output register still full waits for m_tready. The entry memory has a
// single read port with a registered read, which gives entries one at a time
// to the shared source comparator.
module coalescing_event_queue #(
    parameter int QUEUE_DEPTH   = cevq_pkg::DEF_QUEUE_DEPTH,
    parameter int PAYLOAD_WIDTH = cevq_pkg::DEF_PAYLOAD_WIDTH,
    localparam int IN_W  = ((cevq_pkg::SRC_W + PAYLOAD_WIDTH + 7) / 8) * 8,
    localparam int RES_W = 1 + cevq_pkg::SRC_W + PAYLOAD_WIDTH + cevq_pkg::FILL_W + 2
                           + cevq_pkg::TOTAL_W,
    localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // in_source_id, in_payload
    input  logic [IN_W-1:0]             s_tdata,
    // operation
    input  logic [cevq_pkg::OP_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // ok, out_source_id, out_payload, fill_level, is_full, is_empty,
    // coalesced_total
    output logic [OUT_W-1:0]            m_tdata,
    input  logic                        cfg_write,
    input  logic                        cfg_addr,
    input  logic [cevq_pkg::CFG_W-1:0]  cfg_data
);

    import cevq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int EW = SRC_W + PAYLOAD_WIDTH;

    logic [CAP_W-1:0] capacity_reg;
    logic [SRC_W-1:0] system_source_reg;
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic                     res_free;
    logic                     res_done;
    logic [SRC_W-1:0]         res_source;
    logic [PAYLOAD_WIDTH-1:0] res_payload;
    status_t                  res_status;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [EW-1:0] mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [EW-1:0] mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg      <= CAP_RESET;
            system_source_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                CFG_CAPACITY:      capacity_reg      <= cfg_data[CAP_W-1:0];
                CFG_SYSTEM_SOURCE: system_source_reg <= cfg_data[SRC_W-1:0];
                default:           capacity_reg      <= capacity_reg;
            endcase
        end
    end

    cevq_ctrl #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser),
        .in_source     (s_tdata[SRC_W-1:0]),
        .in_payload    (s_tdata[SRC_W +: PAYLOAD_WIDTH]),
        .capacity      (capacity_reg),
        .system_source (system_source_reg),
        .res_free      (res_free),
        .res_done      (res_done),
        .res_source    (res_source),
        .res_payload   (res_payload),
        .res_status    (res_status),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    cevq_store #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The output register frees up in the same cycle that its item is taken.
    assign res_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_done)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_done)
        begin
            m_data_reg <= OUT_W'({res_status.coalesced_total,
                                  res_status.is_empty,
                                  res_status.is_full,
                                  res_status.fill_level,
                                  res_payload,
                                  res_source,
                                  res_status.ok});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
